[rtl/pcc_pkg.sv]
package pcc_pkg;

	// closed cluster, handed from the accumulator to the divider
	typedef struct packed {
		logic [31:0] start_mz;
		logic [31:0] abundance_sum;
		logic [63:0] weighted_sum;
		logic        saturated;
		logic        last;
	} rec_t;

	// enqueue request from the front end: up to two records per beat
	typedef struct packed {
		logic w0_valid;
		logic w1_valid;
		rec_t rec0;
		rec_t rec1;
	} push_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = 2;

endpackage

[rtl/pcc_front.sv]
module pcc_front #(
	parameter int MZ_FRAC_BITS = 16,
	parameter int ABUNDANCE_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         peak_mz,
	input  logic [23:0]         peak_abundance,
	input  logic                last_peak,
	input  logic                q_space,
	output pcc_pkg::push_t      push
);

	localparam logic [31:0] TOL_RESET = 32'(((64'd1 << MZ_FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [23:0] AB_MASK = (ABUNDANCE_BITS >= 24) ? 24'hFFFFFF :
		24'((64'd1 << ABUNDANCE_BITS) - 64'd1);

	logic [31:0] tolerance_q;
	logic        open_f_q;
	logic [31:0] start_f_q;

	logic        s1_v_q;
	logic [31:0] mz_s1;
	logic [23:0] ab_s1;
	logic [55:0] prod_s1;
	logic        newc_s1;
	logic        last_s1;

	logic        open_a_q;
	logic [31:0] start_q;
	logic [31:0] asum_q;
	logic [63:0] wsum_q;
	logic        sat_q;

	logic        take;
	logic        accept;
	logic [23:0] ab_in;
	logic [32:0] mz_delta;
	logic        join_c;
	logic        newc;
	logic [31:0] base_a;
	logic [63:0] base_w;
	logic [32:0] a33;
	logic [64:0] w65;
	logic [31:0] a_new;
	logic [63:0] w_new;
	logic        sat_new;
	logic [31:0] start_new;
	logic        close;
	pcc_pkg::rec_t rec_a;
	pcc_pkg::rec_t rec_b;

	assign take = s1_v_q && q_space;
	assign in_ready = !s1_v_q || take;
	assign accept = in_valid && in_ready;
	assign ab_in = peak_abundance & AB_MASK;

	// signed distance from cluster start against unsigned tolerance
	assign mz_delta = {1'b0, peak_mz} - {1'b0, start_f_q};
	assign join_c = $signed(mz_delta) < $signed({1'b0, tolerance_q});
	assign newc = !open_f_q || !join_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
			open_f_q <= 1'b0;
			start_f_q <= '0;
			s1_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tolerance_q <= cfg_wdata;
			end
			if (accept) begin
				if (newc) begin
					start_f_q <= peak_mz;
				end
				open_f_q <= !last_peak;
				s1_v_q <= 1'b1;
			end else if (take) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mz_s1 <= peak_mz;
			ab_s1 <= ab_in;
			prod_s1 <= 56'(peak_mz) * 56'(ab_in);
			newc_s1 <= newc;
			last_s1 <= last_peak;
		end
	end

	assign base_a = newc_s1 ? 32'd0 : asum_q;
	assign base_w = newc_s1 ? 64'd0 : wsum_q;
	assign a33 = {1'b0, base_a} + 33'(ab_s1);
	assign w65 = {1'b0, base_w} + 65'(prod_s1);
	assign a_new = a33[32] ? 32'hFFFFFFFF : a33[31:0];
	assign w_new = w65[64] ? 64'hFFFFFFFFFFFFFFFF : w65[63:0];
	assign sat_new = (newc_s1 ? 1'b0 : sat_q) | a33[32] | w65[64];
	assign start_new = newc_s1 ? mz_s1 : start_q;
	assign close = newc_s1 && open_a_q;

	always_comb begin
		rec_a.start_mz = start_q;
		rec_a.abundance_sum = asum_q;
		rec_a.weighted_sum = wsum_q;
		rec_a.saturated = sat_q;
		rec_a.last = 1'b0;
		rec_b.start_mz = start_new;
		rec_b.abundance_sum = a_new;
		rec_b.weighted_sum = w_new;
		rec_b.saturated = sat_new;
		rec_b.last = 1'b1;
		push.w0_valid = take && (close || last_s1);
		push.w1_valid = take && close && last_s1;
		push.rec0 = close ? rec_a : rec_b;
		push.rec1 = rec_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_a_q <= 1'b0;
		end else if (take) begin
			open_a_q <= !last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_q <= start_new;
			asum_q <= a_new;
			wsum_q <= w_new;
			sat_q <= sat_new;
		end
	end

endmodule

[rtl/pcc_queue.sv]
module pcc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  pcc_pkg::push_t push,
	output logic           q_space,
	input  logic           pop,
	output logic           empty,
	output pcc_pkg::rec_t  head,
	output logic [2:0]     count
);

	pcc_pkg::rec_t mem [pcc_pkg::QUEUE_DEPTH];
	logic [pcc_pkg::QPTR_BITS-1:0] wp_q;
	logic [pcc_pkg::QPTR_BITS-1:0] rp_q;
	logic [2:0] cnt_q;
	logic [2:0] n_wr;
	logic [2:0] n_rd;

	assign n_wr = 3'(push.w0_valid) + 3'(push.w1_valid);
	assign n_rd = 3'(pop);
	// room for a full two-record beat
	assign q_space = cnt_q <= 3'(pcc_pkg::QUEUE_DEPTH - 2);
	assign empty = cnt_q == 3'd0;
	assign head = mem[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push.w0_valid) begin
			mem[wp_q] <= push.rec0;
		end
		if (push.w1_valid) begin
			mem[wp_q + 2'd1] <= push.rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + n_wr[1:0];
			rp_q <= rp_q + n_rd[1:0];
			cnt_q <= cnt_q + n_wr - n_rd;
		end
	end

endmodule

[rtl/pcc_back.sv]
module pcc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  pcc_pkg::rec_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   centroid_mz,
	output logic [31:0]   total_abundance,
	output logic          zero_weight,
	output logic          sum_saturated,
	output logic          last_cluster
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]  state_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] div_q;
	logic [31:0] cen_q;
	logic [31:0] tot_q;
	logic        zw_q;
	logic        sat_q;
	logic        last_q;
	logic [32:0] trial;
	logic        qbit;
	logic [32:0] diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, lo_q[31]};
	assign diff = trial - {1'b0, div_q};
	assign qbit = !diff[32];
	assign pop = (state_q == ST_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						if (head.abundance_sum == 32'd0 ||
							head.weighted_sum[63:32] >= head.abundance_sum) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_DIV;
							cnt_q <= '0;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					tot_q <= head.abundance_sum;
					sat_q <= head.saturated;
					last_q <= head.last;
					zw_q <= head.abundance_sum == 32'd0;
					div_q <= head.abundance_sum;
					rem_q <= head.weighted_sum[63:32];
					lo_q <= head.weighted_sum[31:0];
					if (head.abundance_sum == 32'd0) begin
						cen_q <= head.start_mz;
					end else begin
						// quotient would not fit: clamp
						cen_q <= 32'hFFFFFFFF;
					end
				end
			end
			ST_DIV: begin
				rem_q <= qbit ? diff[31:0] : trial[31:0];
				lo_q <= {lo_q[30:0], qbit};
				if (cnt_q == 5'd31) begin
					cen_q <= {lo_q[30:0], qbit};
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = state_q == ST_OUT;
	assign centroid_mz = cen_q;
	assign total_abundance = tot_q;
	assign zero_weight = zw_q;
	assign sum_saturated = sat_q;
	assign last_cluster = last_q;

endmodule

[rtl/peak_cluster_centroider.sv]
// Groups a stream of spectrum peaks into clusters (peaks less than the
// tolerance register above the cluster's first peak) and emits, per cluster,
// the abundance-weighted mean mz and saturating summed abundance. The front
// end takes one peak per cycle while the queue has room (multiply stage,
// then accumulate); closed clusters go through a four-entry queue to a
// divider that handles one cluster at a time (pop, 32 radix-2 steps, output)
// and skips the steps when the quotient is clamped or the weight is zero.
// Once the queue fills, the divider sets the pace of the peaks.
module peak_cluster_centroider #(
	parameter int MZ_FRAC_BITS = 16,
	parameter int ABUNDANCE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] peak_mz,
	input  logic [23:0] peak_abundance,
	input  logic        last_peak,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] centroid_mz,
	output logic [31:0] total_abundance,
	output logic        zero_weight,
	output logic        sum_saturated,
	output logic        last_cluster
);

	pcc_pkg::push_t push;
	pcc_pkg::rec_t  head;
	logic           q_space;
	logic           pop;
	logic           empty;
	logic [2:0]     q_count;

	pcc_front #(
		.MZ_FRAC_BITS(MZ_FRAC_BITS),
		.ABUNDANCE_BITS(ABUNDANCE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.peak_mz(peak_mz),
		.peak_abundance(peak_abundance),
		.last_peak(last_peak),
		.q_space(q_space),
		.push(push)
	);

	pcc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.q_space(q_space),
		.pop(pop),
		.empty(empty),
		.head(head),
		.count(q_count)
	);

	pcc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.centroid_mz(centroid_mz),
		.total_abundance(total_abundance),
		.zero_weight(zero_weight),
		.sum_saturated(sum_saturated),
		.last_cluster(last_cluster)
	);

`ifndef ASSERT_OFF
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= 3'(pcc_pkg::QUEUE_DEPTH))
		else $error("queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.w0_valid |-> q_count <= 3'(pcc_pkg::QUEUE_DEPTH - 2))
		else $error("push without room");
	a_zero_wt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_weight |-> total_abundance == 32'd0)
		else $error("zero weight with nonzero total");
`endif

endmodule
